FILE: rtl/zrc_pkg.sv
`timescale 1ns / 1ps
package zrc_pkg;

  localparam int unsigned ScoreW   = 16;
  localparam int unsigned NewW     = 15;
  localparam int unsigned TotalW   = 22;
  localparam int unsigned SumSqW   = 38;
  localparam int unsigned SumNewW  = 21;
  localparam int unsigned DivW     = 38;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned SqrtIter = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ScoreW-1:0] QOne     = 16'd256;
  localparam logic [NewW-1:0]   ScoreMax = 15'd25600;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_MEAN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TARGET_SPREAD = 2'd1;

  typedef enum logic [1:0] {
    DIV_MEAN  = 2'd0,
    DIV_VAR   = 2'd1,
    DIV_Z     = 2'd2,
    DIV_NMEAN = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic              final_item;
  } in_word_t;

  typedef struct packed {
    logic [NewW-1:0]          new_score;
    logic signed [ScoreW-1:0] z_value;
    logic                     run_end;
    logic [ScoreW-1:0]        orig_mean;
    logic [ScoreW-1:0]        orig_spread;
    logic [NewW-1:0]          new_mean;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [ScoreW-1:0]  value;
  } cfg_word_t;

  typedef struct packed {
    logic     load;
    logic     rd;
    logic     var_pass;
    logic     div_go;
    div_sel_e div_sel;
    logic     cap_mean;
    logic     sqrt_go;
    logic     mul;
    logic     map;
    logic     out_load;
    logic     last;
    logic     clr;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/zrc_stream_if.sv
`timescale 1ns / 1ps
interface zrc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/zrc_ram.sv
`timescale 1ns / 1ps
module zrc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/zrc_ctrl.sv
`timescale 1ns / 1ps
module zrc_ctrl #(
  parameter int unsigned MaxItems = 64,
  localparam int unsigned AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1,
  localparam int unsigned CntW = $clog2(MaxItems + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_final_i,
  output logic               in_ready_o,
  input  logic [CntW-1:0]    count_i,
  input  zrc_pkg::sts_t      sts_i,
  output zrc_pkg::cmd_t      cmd_o,
  output logic [AddrW-1:0]   rd_addr_o
);
  import zrc_pkg::*;

  localparam logic [4:0] S_LOAD      = 5'd0;
  localparam logic [4:0] S_MEAN_GO   = 5'd1;
  localparam logic [4:0] S_MEAN_WAIT = 5'd2;
  localparam logic [4:0] S_VAR_RD    = 5'd3;
  localparam logic [4:0] S_VAR_WAIT  = 5'd4;
  localparam logic [4:0] S_VDIV_GO   = 5'd5;
  localparam logic [4:0] S_VDIV_WAIT = 5'd6;
  localparam logic [4:0] S_SQRT_GO   = 5'd7;
  localparam logic [4:0] S_SQRT_WAIT = 5'd8;
  localparam logic [4:0] S_Z_RD      = 5'd9;
  localparam logic [4:0] S_Z_GO      = 5'd10;
  localparam logic [4:0] S_Z_WAIT    = 5'd11;
  localparam logic [4:0] S_Z_MUL     = 5'd12;
  localparam logic [4:0] S_Z_MAP     = 5'd13;
  localparam logic [4:0] S_NM_GO     = 5'd14;
  localparam logic [4:0] S_NM_WAIT   = 5'd15;
  localparam logic [4:0] S_Z_OUT     = 5'd16;

  logic [4:0]      state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            idx_last;
  logic            fire;

  assign in_ready_o = (state_q == S_LOAD);
  assign fire       = in_valid_i && in_ready_o;
  assign idx_last   = (idx_q == count_i - CntW'(1));
  assign rd_addr_o  = idx_q[AddrW-1:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_MEAN;
    case (state_q)
      S_LOAD: begin
        if (fire) begin
          cmd_o.load = 1'b1;
          // A full store closes the set as well.
          if (in_final_i || (count_i == CntW'(MaxItems - 1))) begin
            state_d = S_MEAN_GO;
          end
        end
      end
      S_MEAN_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_MEAN;
        state_d       = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.cap_mean = 1'b1;
          idx_d          = '0;
          state_d        = S_VAR_RD;
        end
      end
      S_VAR_RD: begin
        cmd_o.rd       = 1'b1;
        cmd_o.var_pass = 1'b1;
        if (idx_last) begin
          idx_d   = '0;
          state_d = S_VAR_WAIT;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      S_VAR_WAIT: begin
        if (!sts_i.pipe_busy) begin
          state_d = S_VDIV_GO;
        end
      end
      S_VDIV_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_VAR;
        state_d       = S_VDIV_WAIT;
      end
      S_VDIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd_o.sqrt_go = 1'b1;
        state_d       = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!sts_i.sqrt_busy) begin
          state_d = S_Z_RD;
        end
      end
      S_Z_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_Z_GO;
      end
      S_Z_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_Z;
        state_d       = S_Z_WAIT;
      end
      S_Z_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_Z_MUL;
        end
      end
      S_Z_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_Z_MAP;
      end
      S_Z_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = idx_last ? S_NM_GO : S_Z_OUT;
      end
      S_NM_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_NMEAN;
        state_d       = S_NM_WAIT;
      end
      S_NM_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_Z_OUT;
        end
      end
      S_Z_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.last     = idx_last;
          if (idx_last) begin
            cmd_o.clr = 1'b1;
            idx_d     = '0;
            state_d   = S_LOAD;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_Z_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end
endmodule

FILE: rtl/zrc_datapath.sv
`timescale 1ns / 1ps
module zrc_datapath #(
  parameter int unsigned MaxItems = 64,
  localparam int unsigned AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1,
  localparam int unsigned CntW = $clog2(MaxItems + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         score_i,
  input  logic                cfg_valid_i,
  input  zrc_pkg::cfg_word_t  cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output zrc_pkg::out_word_t  out_data_o,
  input  zrc_pkg::cmd_t       cmd_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output zrc_pkg::sts_t       sts_o,
  output logic [CntW-1:0]     count_o
);
  import zrc_pkg::*;

  logic [NewW-1:0]    tmean_q;
  logic [ScoreW-1:0]  tspread_q;
  logic [CntW-1:0]    count_q;
  logic [TotalW-1:0]  total_q;
  logic [ScoreW-1:0]  mean_q;
  logic [SumSqW-1:0]  sumsq_q;
  logic [SumNewW-1:0] sumnew_q;
  logic [ScoreW-1:0]  rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmean_q   <= 15'd12800;
      tspread_q <= 16'd2560;
    end else if (cfg_valid_i) begin
      if (cfg_data_i.index == CFG_TARGET_MEAN) begin
        tmean_q <= cfg_data_i.value[NewW-1:0];
      end else if (cfg_data_i.index == CFG_TARGET_SPREAD) begin
        tspread_q <= cfg_data_i.value;
      end
    end
  end

  zrc_ram #(.Width(ScoreW), .Depth(MaxItems)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (score_i),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // Deviation of the word just read from the mean.
  logic signed [16:0] dev;
  logic [15:0]        dev_abs;
  assign dev     = $signed({1'b0, rdata}) - $signed({1'b0, mean_q});
  assign dev_abs = dev[16] ? 16'(-dev) : dev[15:0];

  // Squared deviation pipeline for the variance pass.
  logic        p1_q, p2_q;
  logic [31:0] sq_q;
  logic signed [33:0] sq_full;
  assign sq_full = 34'(dev) * 34'(dev);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= 1'b0;
      p2_q <= 1'b0;
    end else begin
      p1_q <= cmd_i.rd && cmd_i.var_pass;
      p2_q <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_q) begin
      sq_q <= sq_full[31:0];
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [DivCntW-1:0] dcnt_q;
  logic [DivW-1:0]    quo_q, dvd;
  logic [15:0]        rem_q, dvs_q, dvs;
  logic [16:0]        dtrial;
  logic               dge;
  logic [ScoreW-1:0]  root_q;
  logic [ScoreW-1:0]  sd_eff;
  logic [15:0]        n_ext;

  assign n_ext  = 16'(count_q);
  assign sd_eff = (root_q == '0) ? QOne : root_q;
  assign dtrial = {rem_q, quo_q[DivW-1]};
  assign dge    = (dtrial >= {1'b0, dvs_q});

  logic z_neg_q;

  always_comb begin
    dvd = '0;
    dvs = n_ext;
    case (cmd_i.div_sel)
      DIV_MEAN:  dvd = DivW'(total_q);
      DIV_VAR:   dvd = sumsq_q;
      DIV_Z: begin
        dvd = DivW'({dev_abs, 8'h00});
        dvs = sd_eff;
      end
      DIV_NMEAN: dvd = DivW'(sumnew_q);
      default:   dvd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_go) begin
      dcnt_q <= DivCntW'(DivW);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      quo_q   <= dvd;
      rem_q   <= '0;
      dvs_q   <= dvs;
      z_neg_q <= dev[16];
    end else if (dcnt_q != '0) begin
      quo_q <= {quo_q[DivW-2:0], dge};
      rem_q <= dge ? 16'(dtrial - {1'b0, dvs_q}) : dtrial[15:0];
    end
  end

  // Floor square root, one result bit per cycle.
  logic [4:0]  scnt_q;
  logic [31:0] sv_q;
  logic [17:0] srem_q;
  logic [19:0] srem_t, strial;
  logic        sge;

  assign srem_t = {srem_q, sv_q[31:30]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = (srem_t >= strial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.sqrt_go) begin
      scnt_q <= 5'(SqrtIter);
    end else if (scnt_q != '0) begin
      scnt_q <= scnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      sv_q   <= quo_q[31:0];
      srem_q <= '0;
      root_q <= '0;
    end else if (scnt_q != '0) begin
      sv_q   <= {sv_q[29:0], 2'b00};
      srem_q <= sge ? 18'(srem_t - strial) : srem_t[17:0];
      root_q <= {root_q[14:0], sge};
    end
  end

  // Saturated z, its product with the target spread, and the clamped score.
  logic signed [15:0] zsat, z_q;
  logic [24:0]        qz;
  logic signed [32:0] prod_q;
  logic [32:0]        prod_abs;
  logic [24:0]        prod_sh;
  logic signed [34:0] vsum;
  logic [NewW-1:0]    v, v_q;

  assign qz = quo_q[24:0];

  always_comb begin
    if (z_neg_q) begin
      zsat = (qz > 25'd32768) ? 16'sh8000 : 16'(-qz);
    end else begin
      zsat = (qz > 25'd32767) ? 16'sh7fff : 16'(qz);
    end
  end

  assign prod_abs = prod_q[32] ? 33'(-prod_q) : prod_q;
  assign prod_sh  = prod_abs[32:8];
  assign vsum     = $signed({20'b0, tmean_q})
                  + (prod_q[32] ? -$signed({10'b0, prod_sh}) : $signed({10'b0, prod_sh}));

  always_comb begin
    if (vsum < 0) begin
      v = '0;
    end else if (vsum > $signed({20'b0, ScoreMax})) begin
      v = ScoreMax;
    end else begin
      v = vsum[NewW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      z_q    <= zsat;
      prod_q <= 33'(zsat) * 33'($signed({1'b0, tspread_q}));
    end
    if (cmd_i.map) begin
      v_q <= v;
    end
    if (cmd_i.cap_mean) begin
      mean_q <= quo_q[ScoreW-1:0];
    end
  end

  // Set counters and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      sumsq_q  <= '0;
      sumnew_q <= '0;
    end else if (cmd_i.clr) begin
      count_q  <= '0;
      total_q  <= '0;
      sumsq_q  <= '0;
      sumnew_q <= '0;
    end else begin
      if (cmd_i.load) begin
        count_q <= count_q + CntW'(1);
        total_q <= total_q + TotalW'(score_i);
      end
      if (p2_q) begin
        sumsq_q <= sumsq_q + SumSqW'(sq_q);
      end
      if (cmd_i.map) begin
        sumnew_q <= sumnew_q + SumNewW'(v);
      end
    end
  end

  // Output word register.
  logic      out_valid_q;
  out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.new_score   <= v_q;
      out_q.z_value     <= z_q;
      out_q.run_end     <= cmd_i.last;
      out_q.orig_mean   <= cmd_i.last ? mean_q : '0;
      out_q.orig_spread <= cmd_i.last ? root_q : '0;
      out_q.new_mean    <= cmd_i.last ? quo_q[NewW-1:0] : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign count_o         = count_q;
  assign sts_o.div_busy  = (dcnt_q != '0);
  assign sts_o.sqrt_busy = (scnt_q != '0);
  assign sts_o.pipe_busy = p1_q || p2_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
endmodule

FILE: rtl/zscore_rescale_clamp.sv
`timescale 1ns / 1ps
// Channel  Dir  Word                             Handshake
// in_i     in   score, final_item                valid/ready
// out_o    out  new_score, z_value, run_end,     valid/ready
//               orig_mean, orig_spread, new_mean
// cfg_i    in   index, value                     valid/ready, always ready
//
// Scores load at one per cycle into the score store, but only while no set is
// in work. The word that closes a set starts the mean divide, variance pass,
// variance divide and square root; then each score takes a z divide on the
// shared divider, and the last one also the new-mean divide.
// Reset clears the counters, accumulators and valid flags, not the store.
// A stalled output word holds its register; the next word waits for it.
module zscore_rescale_clamp #(
  parameter int unsigned MaxItems = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  zrc_stream_if.sink        in_i,
  zrc_stream_if.source      out_o,
  zrc_stream_if.sink        cfg_i
);
  import zrc_pkg::*;

  localparam int unsigned AddrW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW  = $clog2(MaxItems + 1);

  cmd_t             cmd;
  sts_t             sts;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0]  count;
  in_word_t         in_w;
  out_word_t        out_w;
  cfg_word_t        cfg_w;

  assign in_w        = in_i.data;
  assign cfg_w       = cfg_i.data;
  assign cfg_i.ready = 1'b1;
  assign out_o.data  = out_w;

  zrc_ctrl #(.MaxItems(MaxItems)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_final_i (in_w.final_item),
    .in_ready_o (in_i.ready),
    .count_i    (count),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  zrc_datapath #(.MaxItems(MaxItems)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .score_i     (in_w.score),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_w),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_w),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .sts_o       (sts),
    .count_o     (count)
  );
endmodule
